>>> src/stack_arena_allocator_assert.svh
// Assertion macros for the stack arena allocator.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef STACK_ARENA_ALLOCATOR_ASSERT_SVH
`define STACK_ARENA_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SAA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("saa assertion failed");

// Next-cycle implication.
`define SAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("saa assertion failed");

`else

`define SAA_ASSERT_IMPL(label, ante, cons)
`define SAA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/saa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

  // Default sizing
  localparam int DEF_BUF_BYTES   = 4096;
  localparam int DEF_DESC_BYTES  = 8;
  localparam int DEF_MAX_RECORDS = 512;

  // Fixed field widths
  localparam int OP_W    = 1;
  localparam int REQ_W   = 16;
  localparam int OFS_W   = 16;
  localparam int GRANT_W = 12;

  // Allocation granule is four bytes
  localparam int ALIGN_MASK = 3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_DECIDE,
    S_REL_CHECK,
    S_RESULT
  } saa_state_t;

  typedef struct packed {
    logic load;        // capture input transaction, seed search index
    logic calc_need;   // register the space check sum
    logic push;        // commit an allocation
    logic rd_issue;    // read the record below the search index
    logic rel_commit;  // roll back to the matched record
    logic set_result;  // latch pending result
    logic res_ok;      // pending result is a success
    logic grant_fp;    // pending grant is the current free pointer
    logic emit;        // move pending result to the output register
  } saa_cmd_t;

  typedef struct packed {
    logic is_release;
    logic in_range;
    logic idx_zero;
    logic alloc_ok;
    logic match;
    logic out_free;
  } saa_sts_t;

endpackage

`default_nettype wire

>>> src/stack_arena_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Stack-style arena allocator over a BUF_BYTES buffer; one result per request.
// Input channel (in_valid/in_ready): in_operation selects allocate or release;
//   allocate uses in_request_bytes (rounded up to four), release uses
//   in_block_offset and drops that region and every newer one.
// Result channel (out_valid/out_ready): out_status 0 success, 1 failure;
//   out_granted_offset holds the region start on a granted allocate, else 0.
// Sequence: an allocate passes through dispatch, where the space check sum is
//   registered, and a decide state; a release walks the records from newest
//   to oldest until one matches or the oldest is passed, and an out-of-range
//   or empty-stack release fails at dispatch. Requests are served one at a
//   time: the sequencer returns to idle after each result before the next.
//   The release walk reads one record per cycle from the record memory.
// Reset: synchronous, active low; free pointer and record count clear to zero.
//   The record memory is not cleared: only entries below the count are read.
// Stall: a finished result sits in the output register while out_ready is
//   low; the next request is still taken and worked on, and its result waits
//   in a pending register until the output register frees up.
module stack_arena_allocator
  import saa_pkg::*;
#(
  parameter int BUF_BYTES   = DEF_BUF_BYTES,
  parameter int DESC_BYTES  = DEF_DESC_BYTES,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [REQ_W-1:0]   in_request_bytes,
  input  wire logic [OFS_W-1:0]   in_block_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic [GRANT_W-1:0]      out_granted_offset
);

  // Command and status between sequencer and datapath
  saa_cmd_t cmd;
  saa_sts_t sts;

  saa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Pointer, count, record memory and result registers
  saa_dpath #(
    .BUF_BYTES   (BUF_BYTES),
    .DESC_BYTES  (DESC_BYTES),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_request_bytes   (in_request_bytes),
    .in_block_offset    (in_block_offset),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset)
  );

endmodule

`default_nettype wire

>>> src/saa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module saa_ctrl
  import saa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire saa_sts_t sts,
  output saa_cmd_t      cmd
);

  saa_state_t state_r;
  saa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_release) begin
          if (!sts.in_range || sts.idx_zero) begin
            cmd.set_result = 1'b1;
            state_nxt      = S_RESULT;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_REL_CHECK;
          end
        end else begin
          cmd.calc_need = 1'b1;
          state_nxt     = S_ALLOC_DECIDE;
        end
      end
      S_ALLOC_DECIDE: begin
        cmd.set_result = 1'b1;
        if (sts.alloc_ok) begin
          cmd.push     = 1'b1;
          cmd.res_ok   = 1'b1;
          cmd.grant_fp = 1'b1;
        end
        state_nxt = S_RESULT;
      end
      S_REL_CHECK: begin
        priority if (sts.match) begin
          cmd.rel_commit = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_ok     = 1'b1;
          state_nxt      = S_RESULT;
        end else if (sts.idx_zero) begin
          cmd.set_result = 1'b1;
          state_nxt      = S_RESULT;
        end else begin
          // advance to the next older record
          cmd.rd_issue = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/saa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stack_arena_allocator_assert.svh"

module saa_dpath
  import saa_pkg::*;
#(
  parameter int BUF_BYTES   = DEF_BUF_BYTES,
  parameter int DESC_BYTES  = DEF_DESC_BYTES,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [REQ_W-1:0]   in_request_bytes,
  input  wire logic [OFS_W-1:0]   in_block_offset,
  input  wire saa_cmd_t           cmd,
  output saa_sts_t                sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_status,
  output logic [GRANT_W-1:0]      out_granted_offset
);

  localparam int FPW    = $clog2(BUF_BYTES);
  localparam int CNTW   = $clog2(MAX_RECORDS + 1);
  localparam int IDXW   = $clog2(MAX_RECORDS);
  localparam int SIZE_W = REQ_W + 1;
  localparam int CMP_W  = OFS_W + 1;
  localparam int NEED_W =
    $clog2(BUF_BYTES + (1 << REQ_W) + (MAX_RECORDS + 1) * DESC_BYTES) + 1;

  // Captured transaction
  logic [OP_W-1:0]  op_r;
  logic [REQ_W-1:0] req_r;
  logic [OFS_W-1:0] off_r;

  // Allocator state
  logic [FPW-1:0]   fp_r;
  logic [CNTW-1:0]  count_r;
  logic [CNTW-1:0]  idx_r;
  logic [NEED_W-1:0] need_r;

  // Record store
  logic [FPW-1:0]   rec_mem [MAX_RECORDS];
  logic [FPW-1:0]   rdata_r;

  // Results
  logic               res_status_r;
  logic [GRANT_W-1:0] res_grant_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [GRANT_W-1:0] out_grant_r;

  logic [SIZE_W-1:0] size_c;
  logic [NEED_W-1:0] desc_c;
  logic [NEED_W-1:0] need_nxt;
  logic [CNTW-1:0]   idx_dec;

  assign size_c   = ({1'b0, req_r} + SIZE_W'(ALIGN_MASK)) & ~SIZE_W'(ALIGN_MASK);
  assign desc_c   = (NEED_W'(count_r) + NEED_W'(1)) * NEED_W'(DESC_BYTES);
  assign need_nxt = NEED_W'(fp_r) + NEED_W'(size_c) + desc_c;
  assign idx_dec  = idx_r - CNTW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      req_r <= in_request_bytes;
      off_r <= in_block_offset;
    end
    if (cmd.calc_need) begin
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r    <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= count_r;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_dec;
      end
      if (cmd.push) begin
        fp_r    <= fp_r + size_c[FPW-1:0];
        count_r <= count_r + CNTW'(1);
      end else if (cmd.rel_commit) begin
        // drop the matched record and all newer ones
        fp_r    <= off_r[FPW-1:0];
        count_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rec_mem[count_r[IDXW-1:0]] <= fp_r;
    end
    if (cmd.rd_issue) begin
      rdata_r <= rec_mem[idx_dec[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status_r <= cmd.res_ok ? STATUS_OK : STATUS_FAIL;
      res_grant_r  <= (cmd.res_ok && cmd.grant_fp) ? GRANT_W'(fp_r) : '0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.is_release = (op_r == OP_RELEASE);
    sts.in_range   = ({1'b0, off_r} < CMP_W'(BUF_BYTES));
    sts.idx_zero   = (idx_r == '0);
    sts.alloc_ok   = (count_r < CNTW'(MAX_RECORDS)) && (need_r < NEED_W'(BUF_BYTES));
    sts.match      = (rdata_r == off_r[FPW-1:0]);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_grant_r;

  `SAA_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNTW'(MAX_RECORDS))
  `SAA_ASSERT_IMPL(a_push_has_room, cmd.push, count_r < CNTW'(MAX_RECORDS))
  `SAA_ASSERT_NEXT(a_push_grows, cmd.push, count_r == $past(count_r) + CNTW'(1))
  `SAA_ASSERT_NEXT(a_release_shrinks, cmd.rel_commit, count_r < $past(count_r))
  `SAA_ASSERT_IMPL(a_emit_free, cmd.emit, !out_valid_r || out_ready)

endmodule

`default_nettype wire
